>>> rtl/core/nnfs_pkg.sv
// Package for the nearest-neighbor frame scaler: item structs, register
// indexes, action codes and fixed sizes. No dependencies.
package nnfs_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int DIM_W          = 11;
    localparam int POS_W          = 10;
    localparam int PIX_W          = 16;
    localparam int IDX_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_DEST_DIM   = 1024;
    localparam int DEF_SRC_WIDTH  = 320;
    localparam int DEF_SRC_HEIGHT = 200;
    localparam int DEST_W_RESET   = 320;
    localparam int DEST_H_RESET   = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 2'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EMIT  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] src_index;
        logic [PIX_W-1:0] src_pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic             row_end;
        logic             frame_end;
    } t_out_item;

endpackage

>>> rtl/core/nearest_neighbor_frame_scaler.sv
// Nearest-neighbor frame scaler: source frame memory, x.16 fixed-point position
// accumulators, shared bit-serial step divider. Depends on nnfs_pkg.
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ----------------------
// in        to block   i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out       from block o_out_valid / i_out_stall  o_out_data (t_out_item)
// cfg       to block   i_cfg_we (no wait)         i_cfg_index, i_cfg_wdata
//
// One input transfer per cycle while o_in_stall is low. An emit transfer
// reads the frame memory into r_rd_data; the read stage moves the pixel to
// the output register when it is free. A size register write restarts the
// frame, recomputing both steps in a one-bit-per-cycle divider; input stalls.
// Synchronous active-low reset; the frame memory is not cleared.
// Output stall back-pressures through one held read stage to o_in_stall.
module nearest_neighbor_frame_scaler #(
    parameter int SRC_WIDTH  = nnfs_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = nnfs_pkg::DEF_SRC_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  nnfs_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output nnfs_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [nnfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nnfs_pkg::DIM_W-1:0]      i_cfg_wdata
);
    import nnfs_pkg::*;

    // Fixed-point widths: a step or accumulator stays below (SRC << 16),
    // except the step for a size of one, which equals it.
    localparam int CW  = $clog2(SRC_WIDTH + 1) + FRAC_BITS;
    localparam int RW  = $clog2(SRC_HEIGHT + 1) + FRAC_BITS;
    localparam int DW  = (CW > RW) ? CW : RW;
    localparam int SCW = CW - FRAC_BITS;
    localparam int SRW = RW - FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    localparam int FRAME_PIXELS = SRC_WIDTH * SRC_HEIGHT;
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    localparam logic [DW-1:0] COL_DVD = DW'(SRC_WIDTH << FRAC_BITS);
    localparam logic [DW-1:0] ROW_DVD = DW'(SRC_HEIGHT << FRAC_BITS);
    localparam logic [CW-1:0] COL_STEP_RST = CW'((SRC_WIDTH << FRAC_BITS) / DEST_W_RESET);
    localparam logic [RW-1:0] ROW_STEP_RST = RW'((SRC_HEIGHT << FRAC_BITS) / DEST_H_RESET);

    // divider sequencer
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COL  = 2'd1;
    localparam logic [1:0] S_ROW  = 2'd2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DEST_DIM)) begin
            r = DIM_W'(MAX_DEST_DIM);
        end
        return r;
    endfunction

    // size and position state
    logic [DIM_W-1:0] r_dest_width, r_dest_height;
    logic [DIM_W-1:0] r_col_cnt, r_row_cnt;
    logic [CW-1:0]    r_col_acc, r_col_step;
    logic [RW-1:0]    r_row_acc, r_row_step;

    // divider
    logic [1:0]       r_state;
    logic [DW-1:0]    r_dvd;
    logic [DIM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;

    // read stage and output register
    logic             r_s1_valid;
    logic [POS_W-1:0] r_s1_x, r_s1_y;
    logic             r_s1_row_end, r_s1_frame_end;
    logic [PIX_W-1:0] r_rd_data;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [PIX_W-1:0] mem [FRAME_PIXELS];

    logic             w_out_free, w_in_acc, w_emit, w_wr;
    logic             w_last_col, w_last_row;
    logic [SCW-1:0]   w_sc;
    logic [SRW-1:0]   w_sr;
    logic [31:0]      w_rd_addr, w_wr_addr;
    logic [DIM_W-1:0] w_divisor, w_rem_nx;
    logic [DIM_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DW-1:0]    w_quo;
    logic [DIM_W-1:0] n_dest_width, n_dest_height;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) | (r_s1_valid & ~w_out_free);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_emit     = w_in_acc & (i_in_data.action == ACT_EMIT);
    assign w_wr       = w_in_acc & (i_in_data.action == ACT_WRITE)
                      & (32'(i_in_data.src_index) < 32'(FRAME_PIXELS));

    // Source position: integer part of the accumulators, clamped to the last pixel.
    assign w_sc = (r_col_acc[CW-1:FRAC_BITS] >= SCW'(SRC_WIDTH))
                ? SCW'(SRC_WIDTH - 1) : r_col_acc[CW-1:FRAC_BITS];
    assign w_sr = (r_row_acc[RW-1:FRAC_BITS] >= SRW'(SRC_HEIGHT))
                ? SRW'(SRC_HEIGHT - 1) : r_row_acc[RW-1:FRAC_BITS];
    assign w_rd_addr = 32'(w_sr) * 32'(SRC_WIDTH) + 32'(w_sc);
    assign w_wr_addr = 32'(i_in_data.src_index);

    assign w_last_col = ({1'b0, r_col_cnt} + (DIM_W+1)'(1)) >= {1'b0, r_dest_width};
    assign w_last_row = ({1'b0, r_row_cnt} + (DIM_W+1)'(1)) >= {1'b0, r_dest_height};

    // Restoring divide, one quotient bit per cycle.
    assign w_divisor = (r_state == S_ROW) ? r_dest_height : r_dest_width;
    assign w_rem_sh  = {r_rem, r_dvd[DW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, w_divisor};
    assign w_rem_nx  = w_ge ? DIM_W'(w_rem_sh - {1'b0, w_divisor}) : DIM_W'(w_rem_sh);
    assign w_quo     = {r_dvd[DW-2:0], w_ge};

    always_comb begin
        n_dest_width  = r_dest_width;
        n_dest_height = r_dest_height;
        case (i_cfg_index)
            CFG_DEST_WIDTH:  n_dest_width  = clamp_dim(i_cfg_wdata);
            CFG_DEST_HEIGHT: n_dest_height = clamp_dim(i_cfg_wdata);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_wr_addr[AW-1:0]] <= i_in_data.src_pixel;
        end
        if (w_emit) begin
            r_rd_data <= mem[w_rd_addr[AW-1:0]];
        end
    end

    // Position counters, sizes and the step divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= clamp_dim(DIM_W'(DEST_W_RESET));
            r_dest_height <= clamp_dim(DIM_W'(DEST_H_RESET));
            r_col_cnt     <= '0;
            r_row_cnt     <= '0;
            r_col_acc     <= '0;
            r_row_acc     <= '0;
            r_col_step    <= COL_STEP_RST;
            r_row_step    <= ROW_STEP_RST;
            r_state       <= S_IDLE;
            r_dvd         <= '0;
            r_rem         <= '0;
            r_cnt         <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_DEST_WIDTH ||
                                  i_cfg_index == CFG_DEST_HEIGHT)) begin
            r_dest_width  <= n_dest_width;
            r_dest_height <= n_dest_height;
            r_col_cnt     <= '0;
            r_row_cnt     <= '0;
            r_col_acc     <= '0;
            r_row_acc     <= '0;
            r_state       <= S_COL;
            r_dvd         <= COL_DVD;
            r_rem         <= '0;
            r_cnt         <= CNT_W'(DW - 1);
        end else begin
            case (r_state)
                S_COL, S_ROW: begin
                    if (r_cnt == '0) begin
                        r_rem <= '0;
                        r_cnt <= CNT_W'(DW - 1);
                        if (r_state == S_COL) begin
                            r_col_step <= w_quo[CW-1:0];
                            r_dvd      <= ROW_DVD;
                            r_state    <= S_ROW;
                        end else begin
                            r_row_step <= w_quo[RW-1:0];
                            r_dvd      <= w_quo;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_rem <= w_rem_nx;
                        r_dvd <= w_quo;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: begin
                    if (w_emit) begin
                        if (w_last_col) begin
                            r_col_cnt <= '0;
                            r_col_acc <= '0;
                            if (w_last_row) begin
                                r_row_cnt <= '0;
                                r_row_acc <= '0;
                            end else begin
                                r_row_cnt <= r_row_cnt + DIM_W'(1);
                                r_row_acc <= r_row_acc + r_row_step;
                            end
                        end else begin
                            r_col_cnt <= r_col_cnt + DIM_W'(1);
                            r_col_acc <= r_col_acc + r_col_step;
                        end
                    end
                end
            endcase
        end
    end

    // Read stage: holds marks while the memory data sits in r_rd_data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_free) begin
            r_s1_valid <= 1'b0;
        end
        if (w_emit) begin
            r_s1_x         <= r_col_cnt[POS_W-1:0];
            r_s1_y         <= r_row_cnt[POS_W-1:0];
            r_s1_row_end   <= w_last_col;
            r_s1_frame_end <= w_last_col & w_last_row;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_s1_valid && w_out_free) begin
            r_out_data.out_pixel <= r_rd_data;
            r_out_data.out_x     <= r_s1_x;
            r_out_data.out_y     <= r_s1_y;
            r_out_data.row_end   <= r_s1_row_end;
            r_out_data.frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // a size write always kicks off the step divider
    a_cfg_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == CFG_DEST_WIDTH || i_cfg_index == CFG_DEST_HEIGHT))
        |=> (r_state == S_COL))
        else $error("size write did not start the divider");

    // a read stage blocked by a stalled output keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("read stage lost an item under output stall");

    // frame end only on the last pixel of a row
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data.frame_end || r_out_data.row_end))
        else $error("frame end without row end");

    // position counters stay inside the destination frame
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_cnt < r_dest_width) && (r_row_cnt < r_dest_height))
        else $error("destination counter out of range");
`endif

endmodule
